// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the mailbox RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low)
`define DCFM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define DCFM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/dcfm_pkg.sv -----
// Package for the dual CPU byte FIFO mailbox: sizes, operation codes, structs.
// Depends on nothing.
`default_nettype none

package dcfm_pkg;

    // FIFO geometry
    localparam int QUEUE_DEPTH = 512;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int BYTE_W      = 8;
    localparam int OP_W        = 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_HOST_PUSH    = 3'd0;
    localparam logic [OP_W-1:0] OP_HOST_POP     = 3'd1;
    localparam logic [OP_W-1:0] OP_HOST_STATUS  = 3'd2;
    localparam logic [OP_W-1:0] OP_SOUND_POP    = 3'd3;
    localparam logic [OP_W-1:0] OP_SOUND_PUSH   = 3'd4;
    localparam logic [OP_W-1:0] OP_SOUND_STATUS = 3'd5;

    // Status byte: bit0 always set, bit1 = FIFO holds data
    localparam logic [BYTE_W-1:0] STATUS_BASE     = 8'h01;
    localparam logic [BYTE_W-1:0] STATUS_HAS_DATA = 8'h02;

    // Request from the top level to one ring
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [BYTE_W-1:0] data;
    } t_ring_req;

    // Status and read data back from one ring
    typedef struct packed {
        logic              full;
        logic              empty;
        logic              has_data_next;
        logic [BYTE_W-1:0] rd_q;
    } t_ring_rsp;

endpackage

`default_nettype wire

// ----- rtl/dcfm_if.sv -----
// Valid/ready channel interfaces for the mailbox input and result transactions.
// Depends on dcfm_pkg.
`default_nettype none

interface dcfm_in_if;
    logic                        valid;
    logic                        ready;
    logic [dcfm_pkg::OP_W-1:0]   operation;
    logic [dcfm_pkg::BYTE_W-1:0] data;
    logic                        lane_enable;

    modport source (output valid, output operation, output data, output lane_enable,
                    input ready);
    modport sink   (input valid, input operation, input data, input lane_enable,
                    output ready);
endinterface

interface dcfm_out_if;
    logic                        valid;
    logic                        ready;
    logic [dcfm_pkg::BYTE_W-1:0] read_data;
    logic                        underflow;
    logic                        overflow;
    logic                        host_ready;
    logic                        sound_ready;

    modport source (output valid, output read_data, output underflow, output overflow,
                    output host_ready, output sound_ready, input ready);
    modport sink   (input valid, input read_data, input underflow, input overflow,
                    input host_ready, input sound_ready, output ready);
endinterface

`default_nettype wire

// ----- rtl/dcfm_ring.sv -----
// One byte ring FIFO of the mailbox: storage memory, read and write pointers.
// Depends on dcfm_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module dcfm_ring (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  dcfm_pkg::t_ring_req  i_req,
    output dcfm_pkg::t_ring_rsp  o_rsp
);

    localparam logic [dcfm_pkg::PTR_W-1:0] PTR_LAST =
        dcfm_pkg::PTR_W'(dcfm_pkg::QUEUE_DEPTH - 1);

    logic [dcfm_pkg::BYTE_W-1:0] r_mem [dcfm_pkg::QUEUE_DEPTH];
    logic [dcfm_pkg::BYTE_W-1:0] r_rd_q;
    logic [dcfm_pkg::PTR_W-1:0]  r_rd_ptr, r_wr_ptr;
    logic [dcfm_pkg::PTR_W-1:0]  n_rd_ptr, n_wr_ptr;
    logic [dcfm_pkg::PTR_W-1:0]  wr_inc, rd_inc;
    logic                        full, empty, do_push, do_pop;

    // Wrapping increments and occupancy
    assign wr_inc  = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
    assign rd_inc  = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
    assign empty   = (r_rd_ptr == r_wr_ptr);
    assign full    = (wr_inc == r_rd_ptr);
    assign do_push = i_req.push && !full;
    assign do_pop  = i_req.pop && !empty;
    assign n_wr_ptr = do_push ? wr_inc : r_wr_ptr;
    assign n_rd_ptr = do_pop  ? rd_inc : r_rd_ptr;

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
        end
    end

    // Storage: write on push, registered read on pop
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_req.data;
        end
        if (do_pop) begin
            r_rd_q <= r_mem[r_rd_ptr];
        end
    end

    assign o_rsp.full          = full;
    assign o_rsp.empty         = empty;
    assign o_rsp.has_data_next = (n_rd_ptr != n_wr_ptr);
    assign o_rsp.rd_q          = r_rd_q;

    `DCFM_ASSERT(a_ptr_range, i_clk, i_rst_n, (r_rd_ptr <= PTR_LAST) && (r_wr_ptr <= PTR_LAST), "ring pointer out of range")
    `DCFM_ASSERT(a_push_fills, i_clk, i_rst_n, do_push |=> !empty, "ring empty after a push")
    `DCFM_ASSERT(a_pop_frees, i_clk, i_rst_n, do_pop |=> !full, "ring full after a pop")

endmodule

`default_nettype wire

// ----- rtl/dual_cpu_byte_fifo_mailbox.sv -----
// Host/sound CPU mailbox: an inbound byte FIFO (host pushes, sound pops) and an
// outbound byte FIFO (sound pushes, host pops), each holding up to QUEUE_DEPTH-1
// bytes. One bus access is one input transaction and yields exactly one result
// transaction. A new access is taken every cycle while results are drained; each
// access is registered first in the decoded access register, beside the registered
// read port of the FIFO memory, and then in the result register that drives out. Pushes to a full FIFO
// are dropped with overflow, pops from an empty FIFO return 0 with underflow.
// Depends on dcfm_pkg, dcfm_if, dcfm_ring and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module dual_cpu_byte_fifo_mailbox (
    input  wire        i_clk,
    input  wire        i_rst_n,
    dcfm_in_if.sink    i_in,
    dcfm_out_if.source o_out
);

    dcfm_pkg::t_ring_req in_req, out_req;
    dcfm_pkg::t_ring_rsp in_rsp, out_rsp;

    logic                        accept, s1_adv;
    logic                        n_use_in_q, n_use_out_q, n_under, n_over;
    logic [dcfm_pkg::BYTE_W-1:0] n_byte;

    // Stage 1: decoded access, waiting on the memory read data
    logic                        r_s1_valid, r_s1_use_in_q, r_s1_use_out_q;
    logic                        r_s1_under, r_s1_over, r_s1_host_rdy, r_s1_sound_rdy;
    logic [dcfm_pkg::BYTE_W-1:0] r_s1_byte;

    // Result register
    logic                        r_out_valid, r_out_under, r_out_over;
    logic                        r_out_host_rdy, r_out_sound_rdy;
    logic [dcfm_pkg::BYTE_W-1:0] r_out_data;

    assign s1_adv     = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign accept     = i_in.valid && i_in.ready;

    // Operation decode into ring requests and stage 1 fields
    always_comb begin
        in_req      = '0;
        out_req     = '0;
        in_req.data  = i_in.data;
        out_req.data = i_in.data;
        n_use_in_q  = 1'b0;
        n_use_out_q = 1'b0;
        n_under     = 1'b0;
        n_over      = 1'b0;
        n_byte      = '0;
        if (accept) begin
            unique case (i_in.operation)
                dcfm_pkg::OP_HOST_PUSH: begin
                    in_req.push = i_in.lane_enable;
                    n_over      = i_in.lane_enable && in_rsp.full;
                end
                dcfm_pkg::OP_HOST_POP: begin
                    out_req.pop = 1'b1;
                    n_under     = out_rsp.empty;
                    n_use_out_q = !out_rsp.empty;
                end
                dcfm_pkg::OP_HOST_STATUS: begin
                    n_byte = dcfm_pkg::STATUS_BASE |
                             (out_rsp.empty ? '0 : dcfm_pkg::STATUS_HAS_DATA);
                end
                dcfm_pkg::OP_SOUND_POP: begin
                    in_req.pop = 1'b1;
                    n_under    = in_rsp.empty;
                    n_use_in_q = !in_rsp.empty;
                end
                dcfm_pkg::OP_SOUND_PUSH: begin
                    out_req.push = 1'b1;
                    n_over       = out_rsp.full;
                end
                dcfm_pkg::OP_SOUND_STATUS: begin
                    n_byte = dcfm_pkg::STATUS_BASE |
                             (in_rsp.empty ? '0 : dcfm_pkg::STATUS_HAS_DATA);
                end
                default: begin
                end
            endcase
        end
    end

    dcfm_ring u_inbound (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (in_req),
        .o_rsp   (in_rsp)
    );

    dcfm_ring u_outbound (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (out_req),
        .o_rsp   (out_rsp)
    );

    // Stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
        if (accept) begin
            r_s1_use_in_q  <= n_use_in_q;
            r_s1_use_out_q <= n_use_out_q;
            r_s1_under     <= n_under;
            r_s1_over      <= n_over;
            r_s1_byte      <= n_byte;
            r_s1_host_rdy  <= out_rsp.has_data_next;
            r_s1_sound_rdy <= in_rsp.has_data_next;
        end
    end

    // Result register: merges popped byte with status or zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_data      <= r_s1_use_in_q  ? in_rsp.rd_q  :
                               r_s1_use_out_q ? out_rsp.rd_q : r_s1_byte;
            r_out_under     <= r_s1_under;
            r_out_over      <= r_s1_over;
            r_out_host_rdy  <= r_s1_host_rdy;
            r_out_sound_rdy <= r_s1_sound_rdy;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.read_data   = r_out_data;
    assign o_out.underflow   = r_out_under;
    assign o_out.overflow    = r_out_over;
    assign o_out.host_ready  = r_out_host_rdy;
    assign o_out.sound_ready = r_out_sound_rdy;

    `DCFM_ASSERT(a_one_fifo_per_access, i_clk, i_rst_n, !((in_req.push || in_req.pop) && (out_req.push || out_req.pop)), "access drives both FIFOs")
    `DCFM_ASSERT(a_one_pop_source, i_clk, i_rst_n, !(r_s1_valid && r_s1_use_in_q && r_s1_use_out_q), "two pop sources selected")
    `DCFM_ASSERT(a_accept_fills_s1, i_clk, i_rst_n, accept |=> r_s1_valid, "accepted transaction lost in stage 1")

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Testbench for dual_cpu_byte_fifo_mailbox: random and directed bus accesses from
// both CPUs, each result checked against a byte-exact model of the two ring FIFOs.
// Depends on dcfm_pkg, dcfm_if and the mailbox RTL.
`timescale 1ns / 100ps

module tb;

    // Operation codes the block leaves unused
    localparam logic [dcfm_pkg::OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [dcfm_pkg::OP_W-1:0] OP_RSVD_7 = 3'd7;

    // FIFO selectors for the model
    localparam int INBOUND  = 0;
    localparam int OUTBOUND = 1;
    localparam int CAPACITY = dcfm_pkg::QUEUE_DEPTH - 1;

    typedef struct packed {
        logic [dcfm_pkg::OP_W-1:0]   op;
        logic [dcfm_pkg::BYTE_W-1:0] data;
        logic                        lane;
    } t_bus_access;

    typedef struct packed {
        logic [dcfm_pkg::BYTE_W-1:0] read_data;
        logic                        underflow;
        logic                        overflow;
        logic                        host_ready;
        logic                        sound_ready;
    } t_mbox_result;

    logic clk;
    logic rst_n;

    dcfm_in_if  in_ch ();
    dcfm_out_if out_ch ();

    dual_cpu_byte_fifo_mailbox dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Model state: two byte rings
    logic [dcfm_pkg::BYTE_W-1:0] ring_mem [2][dcfm_pkg::QUEUE_DEPTH];
    logic [dcfm_pkg::PTR_W-1:0]  ring_rd  [2];
    logic [dcfm_pkg::PTR_W-1:0]  ring_wr  [2];

    t_bus_access  access_queue[$];
    t_mbox_result awaited_results[$];

    // Occupancy as the stimulus generator sees it, only to shape the sequences
    int gen_fill  [2];
    int gen_drops [2];

    int  errors;
    int  checked_cnt;
    int  underflow_cnt;
    int  overflow_cnt;
    int  in_gap;
    int  out_stall;
    bit  in_fire;
    bit  quiet_stretch;

    // ---------------------------------------------------------------- model
    function automatic logic [dcfm_pkg::PTR_W-1:0] ptr_next(
        input logic [dcfm_pkg::PTR_W-1:0] p);
        return (p == dcfm_pkg::PTR_W'(dcfm_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic ring_has_data(input int f);
        return ring_rd[f] != ring_wr[f];
    endfunction

    function automatic logic [dcfm_pkg::BYTE_W-1:0] ring_status(input int f);
        return ring_has_data(f) ? (dcfm_pkg::STATUS_BASE | dcfm_pkg::STATUS_HAS_DATA)
                                : dcfm_pkg::STATUS_BASE;
    endfunction

    task automatic ring_push(input int f, input logic [dcfm_pkg::BYTE_W-1:0] b,
                             output logic ovf);
        logic [dcfm_pkg::PTR_W-1:0] nxt;
        nxt = ptr_next(ring_wr[f]);
        ovf = 1'b0;
        if (nxt == ring_rd[f]) begin
            ovf = 1'b1;
        end else begin
            ring_mem[f][ring_wr[f]] = b;
            ring_wr[f] = nxt;
        end
    endtask

    task automatic ring_pop(input int f, output logic [dcfm_pkg::BYTE_W-1:0] b,
                            output logic unf);
        b   = '0;
        unf = 1'b0;
        if (!ring_has_data(f)) begin
            unf = 1'b1;
        end else begin
            b = ring_mem[f][ring_rd[f]];
            ring_rd[f] = ptr_next(ring_rd[f]);
        end
    endtask

    // One bus access: updates the rings and returns the result it must produce
    task automatic mailbox_access(input t_bus_access acc, output t_mbox_result res);
        logic [dcfm_pkg::BYTE_W-1:0] rd;
        logic unf;
        logic ovf;
        rd  = '0;
        unf = 1'b0;
        ovf = 1'b0;
        case (acc.op)
            dcfm_pkg::OP_HOST_PUSH: begin
                if (acc.lane) ring_push(INBOUND, acc.data, ovf);
            end
            dcfm_pkg::OP_HOST_POP:     ring_pop(OUTBOUND, rd, unf);
            dcfm_pkg::OP_HOST_STATUS:  rd = ring_status(OUTBOUND);
            dcfm_pkg::OP_SOUND_POP:    ring_pop(INBOUND, rd, unf);
            dcfm_pkg::OP_SOUND_PUSH:   ring_push(OUTBOUND, acc.data, ovf);
            dcfm_pkg::OP_SOUND_STATUS: rd = ring_status(INBOUND);
            default: ;
        endcase
        res.read_data   = rd;
        res.underflow   = unf;
        res.overflow    = ovf;
        res.host_ready  = ring_has_data(OUTBOUND);
        res.sound_ready = ring_has_data(INBOUND);
    endtask

    // ------------------------------------------------------------ stimulus
    task automatic add_access(input logic [dcfm_pkg::OP_W-1:0] op,
                              input logic [dcfm_pkg::BYTE_W-1:0] data,
                              input logic lane);
        t_bus_access acc;
        acc.op   = op;
        acc.data = data;
        acc.lane = lane;
        access_queue.push_back(acc);
        case (op)
            dcfm_pkg::OP_HOST_PUSH: begin
                if (lane) begin
                    if (gen_fill[INBOUND] < CAPACITY) gen_fill[INBOUND]++;
                    else gen_drops[INBOUND]++;
                end
            end
            dcfm_pkg::OP_SOUND_PUSH: begin
                if (gen_fill[OUTBOUND] < CAPACITY) gen_fill[OUTBOUND]++;
                else gen_drops[OUTBOUND]++;
            end
            dcfm_pkg::OP_HOST_POP:  if (gen_fill[OUTBOUND] > 0) gen_fill[OUTBOUND]--;
            dcfm_pkg::OP_SOUND_POP: if (gen_fill[INBOUND] > 0) gen_fill[INBOUND]--;
            default: ;
        endcase
    endtask

    // Random access; pop_pct sets how often it is a pop from either side
    task automatic add_random_access(input int pop_pct);
        int r;
        logic [dcfm_pkg::OP_W-1:0] op;
        r = $urandom_range(0, 99);
        if (r < 2) begin
            op = $urandom_range(0, 1) ? OP_RSVD_6 : OP_RSVD_7;
        end else if (r < 2 + pop_pct) begin
            op = $urandom_range(0, 1) ? dcfm_pkg::OP_HOST_POP : dcfm_pkg::OP_SOUND_POP;
        end else begin
            case ($urandom_range(0, 3))
                0:       op = dcfm_pkg::OP_HOST_PUSH;
                1:       op = dcfm_pkg::OP_SOUND_PUSH;
                2:       op = dcfm_pkg::OP_HOST_STATUS;
                default: op = dcfm_pkg::OP_SOUND_STATUS;
            endcase
        end
        add_access(op, dcfm_pkg::BYTE_W'($urandom_range(0, 255)),
                   $urandom_range(0, 7) != 0);
    endtask

    // Gap length for either side: mostly none or short, a few long, quiet stretches
    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 99) == 0) quiet_stretch = !quiet_stretch;
        if (quiet_stretch) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // ---------------------------------------------------------------- clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Drive the input channel at the falling edge
    always @(negedge clk) begin
        t_bus_access acc;
        if (rst_n && (!in_ch.valid || in_fire)) begin
            if (in_gap > 0) begin
                in_ch.valid <= 1'b0;
                in_gap--;
            end else if (access_queue.size() != 0) begin
                acc = access_queue.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.operation   <= acc.op;
                in_ch.data        <= acc.data;
                in_ch.lane_enable <= acc.lane;
                in_gap = pick_gap();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result side backpressure
    always @(negedge clk) begin
        if (rst_n) begin
            if (out_stall > 0) begin
                out_ch.ready <= 1'b0;
                out_stall--;
            end else begin
                out_ch.ready <= 1'b1;
                out_stall = pick_gap();
            end
        end
    end

    // Check results, then record accepted accesses; both at the rising edge
    always @(posedge clk) begin
        t_bus_access  acc;
        t_mbox_result exp;
        t_mbox_result got;
        if (!rst_n) begin
            in_fire = 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.read_data   = out_ch.read_data;
                got.underflow   = out_ch.underflow;
                got.overflow    = out_ch.overflow;
                got.host_ready  = out_ch.host_ready;
                got.sound_ready = out_ch.sound_ready;
                if (awaited_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result transaction %h", $time, got);
                end else begin
                    exp = awaited_results.pop_front();
                    checked_cnt++;
                    if (exp.underflow) underflow_cnt++;
                    if (exp.overflow) overflow_cnt++;
                    if (got !== exp) begin
                        errors++;
                        $display("%0t: result mismatch: expected data=%h unf=%b ovf=%b",
                                 $time, exp.read_data, exp.underflow, exp.overflow,
                                 " hrdy=%b srdy=%b,", exp.host_ready, exp.sound_ready,
                                 " got data=%h unf=%b ovf=%b", got.read_data,
                                 got.underflow, got.overflow,
                                 " hrdy=%b srdy=%b", got.host_ready, got.sound_ready);
                    end
                end
            end
            in_fire = in_ch.valid && in_ch.ready;
            if (in_fire) begin
                acc.op   = in_ch.operation;
                acc.data = in_ch.data;
                acc.lane = in_ch.lane_enable;
                mailbox_access(acc, exp);
                awaited_results.push_back(exp);
            end
        end
    end

    // Run limit
    initial begin
        #1000000;
        $display("tb: errors");
        $finish;
    end

    // ----------------------------------------------------------- main flow
    initial begin
        errors        = 0;
        checked_cnt   = 0;
        underflow_cnt = 0;
        overflow_cnt  = 0;
        in_gap        = 0;
        out_stall     = 0;
        in_fire       = 1'b0;
        quiet_stretch = 1'b0;
        for (int f = 0; f < 2; f++) begin
            ring_rd[f]   = '0;
            ring_wr[f]   = '0;
            gen_fill[f]  = 0;
            gen_drops[f] = 0;
        end
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.operation    = dcfm_pkg::OP_HOST_STATUS;
        in_ch.data         = '0;
        in_ch.lane_enable  = 1'b0;
        out_ch.ready       = 1'b0;

        // Directed: empty pops, status both ways, lane gating, byte extremes,
        // unused codes, drain past empty
        add_access(dcfm_pkg::OP_HOST_POP, 8'h00, 1'b1);
        add_access(dcfm_pkg::OP_SOUND_POP, 8'h00, 1'b1);
        add_access(dcfm_pkg::OP_HOST_STATUS, 8'h00, 1'b1);
        add_access(dcfm_pkg::OP_SOUND_STATUS, 8'h00, 1'b1);
        add_access(dcfm_pkg::OP_HOST_PUSH, 8'hff, 1'b0);
        add_access(dcfm_pkg::OP_SOUND_STATUS, 8'h00, 1'b1);
        add_access(dcfm_pkg::OP_HOST_PUSH, 8'h00, 1'b1);
        add_access(dcfm_pkg::OP_HOST_PUSH, 8'hff, 1'b1);
        add_access(dcfm_pkg::OP_SOUND_STATUS, 8'hff, 1'b0);
        add_access(dcfm_pkg::OP_SOUND_PUSH, 8'hff, 1'b0);
        add_access(dcfm_pkg::OP_SOUND_PUSH, 8'h00, 1'b1);
        add_access(dcfm_pkg::OP_HOST_STATUS, 8'hff, 1'b0);
        add_access(OP_RSVD_6, 8'hff, 1'b1);
        add_access(OP_RSVD_7, 8'hff, 1'b1);
        add_access(dcfm_pkg::OP_SOUND_POP, 8'h00, 1'b0);
        add_access(dcfm_pkg::OP_SOUND_POP, 8'h00, 1'b1);
        add_access(dcfm_pkg::OP_SOUND_POP, 8'h00, 1'b1);
        add_access(dcfm_pkg::OP_HOST_POP, 8'hff, 1'b0);
        add_access(dcfm_pkg::OP_HOST_POP, 8'h00, 1'b1);
        add_access(dcfm_pkg::OP_HOST_POP, 8'h00, 1'b1);
        add_access(dcfm_pkg::OP_HOST_STATUS, 8'h00, 1'b1);
        add_access(dcfm_pkg::OP_SOUND_STATUS, 8'h00, 1'b1);

        // Random traffic near empty
        repeat (80) add_random_access(33);

        // Fill both FIFOs until each has rejected a few pushes
        while (gen_drops[INBOUND] < 3 || gen_drops[OUTBOUND] < 3) begin
            if ($urandom_range(0, 19) == 0)
                add_access($urandom_range(0, 1) ? dcfm_pkg::OP_HOST_STATUS
                                                : dcfm_pkg::OP_SOUND_STATUS,
                           dcfm_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
            else if ($urandom_range(0, 1))
                add_access(dcfm_pkg::OP_HOST_PUSH,
                           dcfm_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
            else
                add_access(dcfm_pkg::OP_SOUND_PUSH,
                           dcfm_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
        end

        // Pop-heavy traffic from full
        repeat (70) add_random_access(60);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for all accesses to go in, then for all results to come out
        while (access_queue.size() != 0 || in_ch.valid) @(negedge clk);
        while (awaited_results.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);

        $display("summary: %0d result transactions checked, %0d underflows, %0d overflows",
                 checked_cnt, underflow_cnt, overflow_cnt);
        $display("summary: both FIFOs filled to capacity, drained past empty and wrapped");
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// ----- dual_cpu_byte_fifo_mailbox.f -----
+incdir+rtl
rtl/dcfm_pkg.sv
rtl/dcfm_if.sv
rtl/dcfm_ring.sv
rtl/dual_cpu_byte_fifo_mailbox.sv
test/tb.sv
